FILE: rtl/b64sc_pkg.sv
// shared types, constants and alphabet functions of the base64 stream codec
package b64sc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3d;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [0:0] REG_DIRECTION = 1'b0;

   // one released group: up to four result items and the index of the final one
   typedef struct packed {
      logic [3:0][7:0] item;
      logic [1:0]      last_idx;
   } group_rec_type;

   typedef struct packed {
      logic          valid;
      group_rec_type rec;
   } group_push_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

   function automatic logic [5:0] char_sextet(input logic [7:0] c);
      logic [7:0] s;
      if (c >= 8'h41 && c <= 8'h5a) begin
         s = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         s = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s = c - 8'h30 + 8'd52;
      end else if (c == 8'h2b) begin
         s = 8'd62;
      end else if (c == 8'h2f) begin
         s = 8'd63;
      end else begin
         s = 8'd0;
      end
      return s[5:0];
   endfunction

endpackage

FILE: rtl/b64sc_front.sv
// front end: takes input items, collects groups and releases group records
module b64sc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     direction,
   input  logic                     group_clear,
   input  logic                     item_accept,
   input  logic [7:0]               data_in,
   input  logic                     last_in,
   output b64sc_pkg::group_push_type push
);

   logic [2:0][7:0] buf_ff, buf_in;
   logic [1:0]      pos_ff, pos_in;
   logic [1:0]      n;
   logic [7:0]      b0, b1, b2;
   logic [5:0]      h0, h1, h2, h3;
   logic [1:0]      last_idx;

   always_comb begin
      buf_in = buf_ff;
      pos_in = pos_ff;
      push   = '0;
      n      = (pos_ff == 2'd3) ? 2'd2 : pos_ff;
      // encode operands, the incoming byte stands in for its own slot
      b0 = (n == 2'd0) ? data_in : buf_ff[0];
      b1 = (n == 2'd1) ? data_in : ((n == 2'd2) ? buf_ff[1] : 8'd0);
      b2 = (n == 2'd2) ? data_in : 8'd0;
      h0 = b64sc_pkg::char_sextet(buf_ff[0]);
      h1 = b64sc_pkg::char_sextet(buf_ff[1]);
      h2 = b64sc_pkg::char_sextet(buf_ff[2]);
      h3 = b64sc_pkg::char_sextet(data_in);
      last_idx = 2'd2;
      if (data_in == b64sc_pkg::PAD_CHAR) last_idx = last_idx - 2'd1;
      if (buf_ff[2] == b64sc_pkg::PAD_CHAR) last_idx = last_idx - 2'd1;

      if (item_accept) begin
         if (direction == b64sc_pkg::DIR_ENCODE) begin
            buf_in[n] = data_in;
            if (n == 2'd2 || last_in) begin
               push.valid        = 1'b1;
               push.rec.item[0]  = b64sc_pkg::sextet_char(b0[7:2]);
               push.rec.item[1]  = b64sc_pkg::sextet_char({b0[1:0], b1[7:4]});
               push.rec.item[2]  = (n != 2'd0) ?
                                   b64sc_pkg::sextet_char({b1[3:0], b2[7:6]}) :
                                   b64sc_pkg::PAD_CHAR;
               push.rec.item[3]  = (n == 2'd2) ? b64sc_pkg::sextet_char(b2[5:0]) :
                                                  b64sc_pkg::PAD_CHAR;
               push.rec.last_idx = 2'd3;
               pos_in            = 2'd0;
            end else begin
               pos_in = n + 2'd1;
            end
         end else begin
            if (pos_ff != 2'd3) begin
               buf_in[pos_ff] = data_in;
               // a short group closed by last is dropped
               pos_in = last_in ? 2'd0 : pos_ff + 2'd1;
            end else begin
               push.valid        = 1'b1;
               push.rec.item[0]  = {h0, h1[5:4]};
               push.rec.item[1]  = {h1[3:0], h2[5:2]};
               push.rec.item[2]  = {h2[1:0], h3};
               push.rec.item[3]  = 8'd0;
               push.rec.last_idx = last_idx;
               pos_in            = 2'd0;
            end
         end
      end
      if (group_clear) pos_in = 2'd0;
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         pos_ff <= 2'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: rtl/b64sc_queue.sv
// short queue of group records between front and back end
module b64sc_queue #(
   parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  b64sc_pkg::group_push_type push,
   input  logic                     pop,
   output logic                     full,
   output b64sc_pkg::group_push_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   b64sc_pkg::group_rec_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.rec   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push.rec;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/b64sc_back.sv
// back end: walks the head record and drives one result per cycle while rsp_tready holds
module b64sc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  b64sc_pkg::group_push_type head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = head.valid && (!valid_ff || rsp_tready);
   assign pop  = load && (idx_ff == head.rec.last_idx);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = head.rec.item[idx_ff];
         last_in  = pop;
         idx_in   = pop ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: rtl/base64_stream_codec.sv
// top level of the streaming base64 codec (standard alphabet, '=' padding)
//
// req channel carries one byte (encode) or one character code (decode) per
// transfer, req_tlast closes the stream. rsp channel carries one character
// (encode) or one byte (decode) per transfer, rsp_tlast marks the final
// result caused by one input transfer.
// the csr port holds the direction register at byte address 0 (0 encode,
// 1 decode); any write to it empties the group being collected. write it
// only while the block is idle.
// encode: every third byte, or a byte with req_tlast, releases four
// characters. decode: every fourth character releases one to three bytes;
// a short group closed by req_tlast is dropped.
// path: the front end and the queue write a released group at the input
// transfer edge; the back end then loads its first result into the output
// register, behind any earlier results and any stall on the rsp side.
// throughput: one input transfer per cycle while the queue has room; the
// output register gives one result per cycle, so long encode runs settle at
// four results per three input transfers, paced by the result channel.
// a stalled rsp side fills the two-entry group queue, then req_tready drops.
// reset clears direction, the group, the queue and the output register.
module base64_stream_codec #(
   parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_in
   input  logic        req_tlast,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                      direction_ff, direction_in;
   logic                      csr_write;
   logic                      dir_write;
   logic                      req_accept;
   logic                      queue_full;
   logic                      queue_pop;
   b64sc_pkg::group_push_type group_push;
   b64sc_pkg::group_push_type queue_head;

   // register port, word aligned, register index in paddr[2]
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign dir_write  = csr_write && (csr_paddr[2] == b64sc_pkg::REG_DIRECTION);
   assign csr_prdata = (csr_paddr[2] == b64sc_pkg::REG_DIRECTION) ?
                       {31'd0, direction_ff} : 32'd0;

   always_comb begin
      direction_in = direction_ff;
      if (dir_write) direction_in = csr_pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= b64sc_pkg::DIR_ENCODE;
      end else begin
         direction_ff <= direction_in;
      end
   end

   // input side stalls only when the group queue has no room
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   b64sc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .direction   (direction_ff),
      .group_clear (dir_write),
      .item_accept (req_accept),
      .data_in     (req_tdata),
      .last_in     (req_tlast),
      .push        (group_push)
   );

   b64sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (group_push),
      .pop   (queue_pop),
      .full  (queue_full),
      .head  (queue_head)
   );

   b64sc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (queue_head),
      .pop        (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a group record is only produced by an accepted input transfer
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      group_push.valid |-> req_accept)
      else $error("group released without input transfer");

   // input stalls only with work waiting in the queue
   a_stall_has_work: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> queue_head.valid)
      else $error("input stalled with empty queue");

   // a result only starts from a queued record
   a_result_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(queue_head.valid))
      else $error("result without queued group");

endmodule

FILE: dv/base64_stream_codec_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the base64 stream codec: directed and random streams, both directions
module base64_stream_codec_test;

   // one stream beat, used for both the input and the result side
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } beat_type;

   // standard alphabet, character of sextet 0 in the top byte
   localparam logic [511:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // register byte addresses: index 0 is direction, index 1 maps to nothing
   localparam logic [2:0] ADDR_DIRECTION = {b64sc_pkg::REG_DIRECTION, 2'b00};
   localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

   // cycles to let pass once nothing is expected, as a margin for the pipe to settle
   localparam int DRAIN_CYCLES = 8;

   // dut ports, every input driven to a known value from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // [7:0] data_in
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;             // [7:0] out_byte
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // input beats waiting for the driver, results the codec owes us
   beat_type src_beats [$];
   beat_type coded_out_q [$];

   // our own copy of the codec state
   logic       dir_mode = b64sc_pkg::DIR_ENCODE;
   logic [7:0] grp_buf [3];
   logic [1:0] grp_fill = 2'd0;

   // idle percentages of the two sides, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int errors       = 0;
   int beats_in     = 0;
   int results_seen = 0;
   int csr_writes   = 0;

   base64_stream_codec DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 2 ns period
   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // codec prediction
   // ---------------------------------------------------------------

   // sextet value to alphabet character
   function automatic logic [7:0] char_of(input logic [5:0] v);
      return ALPHABET[8*(63-v) +: 8];
   endfunction

   // character to sextet, anything outside the alphabet counts as zero
   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] s;
      s = 6'd0;
      for (int i = 0; i < 64; i++)
         if (char_of(i[5:0]) == c) s = i[5:0];
      return s;
   endfunction

   function automatic void clear_group();
      grp_buf[0] = 8'h00;
      grp_buf[1] = 8'h00;
      grp_buf[2] = 8'h00;
      grp_fill   = 2'd0;
   endfunction

   function automatic void push_out(input logic [7:0] data, input logic last);
      beat_type b;
      b.data = data;
      b.last = last;
      coded_out_q.push_back(b);
   endfunction

   // advance the state by one accepted input beat and queue what it releases
   task automatic b64_transcode(input logic [7:0] d, input logic last);
      int n;
      int count;
      logic [7:0] b0, b1, b2;
      logic [5:0] h0, h1, h2, h3;
      logic [7:0] outb [3];
      n = grp_fill;
      if (dir_mode == b64sc_pkg::DIR_ENCODE) begin
         if (n > 2) n = 2;
         grp_buf[n] = d;
         n++;
         if (n < 3 && !last) begin
            grp_fill = n[1:0];
         end else begin
            // full group, or a short one closed by last: pad with '='
            b0 = grp_buf[0];
            b1 = (n >= 2) ? grp_buf[1] : 8'h00;
            b2 = (n >= 3) ? grp_buf[2] : 8'h00;
            push_out(char_of(b0[7:2]), 1'b0);
            push_out(char_of({b0[1:0], b1[7:4]}), 1'b0);
            push_out((n >= 2) ? char_of({b1[3:0], b2[7:6]}) : b64sc_pkg::PAD_CHAR, 1'b0);
            push_out((n >= 3) ? char_of(b2[5:0]) : b64sc_pkg::PAD_CHAR, 1'b1);
            clear_group();
         end
      end else if (n < 3) begin
         // short decode group: a last drops it
         grp_buf[n] = d;
         if (last) clear_group();
         else grp_fill = 2'(n + 1);
      end else begin
         // only the third and fourth characters count as padding
         count = 3 - int'(d == b64sc_pkg::PAD_CHAR)
                   - int'(grp_buf[2] == b64sc_pkg::PAD_CHAR);
         h0 = sextet_of(grp_buf[0]);
         h1 = sextet_of(grp_buf[1]);
         h2 = sextet_of(grp_buf[2]);
         h3 = sextet_of(d);
         outb[0] = {h0, h1[5:4]};
         outb[1] = {h1[3:0], h2[5:2]};
         outb[2] = {h2[1:0], h3};
         for (int k = 0; k < count; k++)
            push_out(outb[k], k == count - 1);
         clear_group();
      end
   endtask

   // ---------------------------------------------------------------
   // driver: presents pending beats, holds each until its transfer
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      beat_type next_beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // transfer at this edge: predict from the values the dut saw
         if (req_tvalid && req_tready) begin
            b64_transcode(req_tdata, req_tlast);
            beats_in++;
         end
         // a beat on the bus stays until taken, new beats may be held back
         if (!req_tvalid || req_tready) begin
            if (src_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = src_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_beat.data;
               req_tlast  <= next_beat.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: random backpressure, each result against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (coded_out_q.size() == 0) begin
               $display("%0t: result with nothing expected: actual data %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = coded_out_q.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: out_byte mismatch: expected %h actual %h",
                           $time, want.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_of_run mismatch: expected %b actual %b",
                           $time, want.last, rsp_tlast);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic void queue_item(input logic [7:0] d, input logic last);
      beat_type b;
      b.data = d;
      b.last = last;
      src_beats.push_back(b);
   endfunction

   // a text of characters, last optionally on the final one
   function automatic void queue_text(input string s, input logic last_on_final);
      for (int i = 0; i < s.len(); i++)
         queue_item(s[i], last_on_final && (i == s.len() - 1));
   endfunction

   // wait until every beat is taken and every result is back, then let the pipe settle
   task automatic wait_idle();
      do @(negedge clock);
      while (src_beats.size() != 0 || req_tvalid || coded_out_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // apb write (setup + access), then a read of direction to check it back
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // register takes the write at this edge; any direction write empties the group
      if (addr[2] == b64sc_pkg::REG_DIRECTION) begin
         dir_mode = value[0];
         clear_group();
      end
      csr_writes++;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_DIRECTION;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[0] !== dir_mode) begin
         $display("%0t: direction read back: expected %b actual %b",
                  $time, dir_mode, csr_prdata[0]);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // random bytes with an occasional end of stream
   task automatic load_encode_run(input int n);
      for (int i = 0; i < n; i++)
         queue_item(8'($urandom_range(255)), $urandom_range(7) == 0);
   endtask

   // mostly well-formed groups, some noise, odd padding and cut-off groups
   task automatic load_decode_run(input int n);
      int count;
      int kind;
      int pad;
      int len;
      logic [7:0] c;
      count = 0;
      while (count < n) begin
         kind = $urandom_range(9);
         if (kind <= 5) begin
            // clean group, '==' or '=' or none at the tail
            pad = $urandom_range(3);
            for (int p = 0; p < 4; p++) begin
               if ((pad == 0 && p >= 2) || (pad == 1 && p == 3)) c = b64sc_pkg::PAD_CHAR;
               else c = char_of(6'($urandom_range(63)));
               queue_item(c, p == 3 && $urandom_range(3) == 0);
            end
            count += 4;
         end else if (kind == 6) begin
            // raw bytes, mostly outside the alphabet
            for (int p = 0; p < 4; p++)
               queue_item(8'($urandom_range(255)), p == 3 && $urandom_range(1) == 0);
            count += 4;
         end else if (kind == 7) begin
            // group cut short by end of stream
            len = $urandom_range(1, 3);
            for (int p = 0; p < len; p++)
               queue_item(char_of(6'($urandom_range(63))), p == len - 1);
            count += len;
         end else if (kind == 8) begin
            // '=' anywhere in the group
            for (int p = 0; p < 4; p++) begin
               c = ($urandom_range(1) == 0) ? b64sc_pkg::PAD_CHAR :
                                              char_of(6'($urandom_range(63)));
               queue_item(c, 1'b0);
            end
            count += 4;
         end else begin
            // stray beat that shifts the grouping
            queue_item(8'($urandom_range(255)), 1'($urandom_range(1)));
            count += 1;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] junk;
      clear_group();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed encode, sender idles lightly, receiver heavily
      send_idle_pct = 25;
      recv_idle_pct = 77;
      @(negedge clock);
      queue_item(8'h00, 1'b0);
      queue_item(8'hff, 1'b0);
      queue_item(8'h80, 1'b0);
      queue_item(8'h7f, 1'b1);   // one byte left at end, two pad characters
      queue_item(8'h01, 1'b0);
      queue_item(8'hfe, 1'b1);   // two bytes left at end, one pad character
      queue_item(8'h55, 1'b0);
      wait_idle();
      // unmapped register: must leave direction and the half group alone
      csr_write(ADDR_UNMAPPED, 32'hffff_ffff);
      @(negedge clock);
      queue_item(8'haa, 1'b0);
      wait_idle();
      // rewriting the same direction still drops the two buffered bytes
      csr_write(ADDR_DIRECTION, {31'h0, b64sc_pkg::DIR_ENCODE});
      @(negedge clock);
      queue_item(8'h12, 1'b0);
      queue_item(8'h34, 1'b0);
      queue_item(8'h56, 1'b1);   // end of stream on a complete group
      wait_idle();

      // directed decode
      junk = $urandom;
      csr_write(ADDR_DIRECTION, {junk[31:1], b64sc_pkg::DIR_DECODE});
      @(negedge clock);
      queue_text("TQ==", 1'b0);  // both tail characters padding
      queue_text("AB=C", 1'b0);  // only the third counts
      queue_item(b64sc_pkg::PAD_CHAR, 1'b0); // nothing here is in the alphabet
      queue_item(8'h80, 1'b0);
      queue_item(8'hff, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_text("QU", 1'b1);    // short group dropped at end of stream
      queue_text("Qk", 1'b0);
      wait_idle();
      // direction write in the middle of a decode group empties it
      csr_write(ADDR_DIRECTION, {31'h0, b64sc_pkg::DIR_DECODE});
      @(negedge clock);
      queue_text("+/9=", 1'b1);  // fourth only, alphabet ends
      wait_idle();

      // random part in three idle patterns, each direction in each
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 0) begin
            send_idle_pct = 25;
            recv_idle_pct = 77;
         end else if (ph == 1) begin
            send_idle_pct = 77;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         junk = $urandom;
         csr_write(ADDR_DIRECTION, {junk[31:1], b64sc_pkg::DIR_ENCODE});
         @(negedge clock);
         load_encode_run(50);
         wait_idle();
         junk = $urandom;
         csr_write(ADDR_DIRECTION, {junk[31:1], b64sc_pkg::DIR_DECODE});
         @(negedge clock);
         load_decode_run(50);
         wait_idle();
      end

      $display("ran %0d input transfers through encode and decode, checked %0d results",
               beats_in, results_seen);
      $display("%0d register writes across both directions, %0d mismatches",
               csr_writes, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog far beyond the slowest correct run
   initial begin
      #200000;
      $display("timeout with %0d results still expected", coded_out_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
